### sv/ps2_device_command_sequencer_core_macros.svh
// Assertion macros shared by the command sequencer RTL.
// Expects signals named clock and reset in the including module.
`ifndef PS2_DEVICE_COMMAND_SEQUENCER_CORE_MACROS_SVH
`define PS2_DEVICE_COMMAND_SEQUENCER_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PS2DCS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PS2DCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/ps2dcs_pkg.sv
// Shared types, constants and helpers of the PS/2 command sequencer.
// No dependencies; used by every RTL module of the block.
package ps2dcs_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = PTR_W;

   localparam int BYTE_W      = 8;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ACK_CODE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESEND_CODE = 1'b1;

   localparam logic [BYTE_W-1:0] ACK_CODE_RESET    = 8'd250;
   localparam logic [BYTE_W-1:0] RESEND_CODE_RESET = 8'd254;

   localparam logic [1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [1:0] ACT_RX      = 2'd1;
   localparam logic [1:0] ACT_POLL    = 2'd2;

   localparam logic [1:0] FWD_NONE     = 2'd0;
   localparam logic [1:0] FWD_DATA     = 2'd1;
   localparam logic [1:0] FWD_CMD_RESP = 2'd2;

   typedef enum logic [1:0] {
      PH_NORMAL    = 2'd0,
      PH_WAIT_ACK  = 2'd1,
      PH_WAIT_RESP = 2'd2
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] resp;
      logic              two;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] cmd;
   } cmd_entry_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [BYTE_W-1:0] cmd_byte;
      logic              has_data;
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] response_count;
      logic [BYTE_W-1:0] rx_byte;
      logic              lock_granted;
   } req_item_type;

   typedef struct packed {
      logic              enqueue_ok;
      logic              send_valid;
      logic [BYTE_W-1:0] send_value;
      logic [1:0]        forward_kind;
      logic [BYTE_W-1:0] forward_value;
      logic              release_lock;
      logic [1:0]        link_phase;
   } rsp_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] ack_code;
      logic [BYTE_W-1:0] resend_code;
   } link_codes_type;

   // Circular queue pointer increment, wraps for any depth.
   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) nxt = '0;
      else nxt = ptr + PTR_W'(1);
      return nxt;
   endfunction

endpackage

### sv/ps2dcs_seq.sv
// Command queue memory and link sequencing logic of the PS/2 command sequencer.
// Depends on ps2dcs_pkg and the shared assertion macro header.
`include "ps2_device_command_sequencer_core_macros.svh"

module ps2dcs_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_valid,
   input  ps2dcs_pkg::req_item_type   item,
   input  ps2dcs_pkg::link_codes_type codes,
   output ps2dcs_pkg::rsp_item_type   rsp
);
   import ps2dcs_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              idx_ff, idx_in;
   logic [BYTE_W-1:0] left_ff, left_in;

   // command store: one write port, two registered read ports (head, head+1)
   cmd_entry_type     store_mem [QUEUE_DEPTH];
   cmd_entry_type     head_rd_ff;
   cmd_entry_type     next_rd_ff;
   logic [PTR_W-1:0]  next_addr;
   logic              wr_en;
   cmd_entry_type     new_entry;
   cmd_entry_type     send_entry;
   logic              pop;
   logic              attempt;

   assign new_entry.cmd  = item.cmd_byte;
   assign new_entry.data = item.has_data ? item.data_byte : '0;
   assign new_entry.two  = item.has_data;
   assign new_entry.resp = item.response_count;
   assign next_addr      = next_slot(head_in);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[tail_ff] <= new_entry;
      end
      // write-through forwarding keeps the prefetched head entries current
      head_rd_ff <= (wr_en && tail_ff == head_in)   ? new_entry : store_mem[head_in];
      next_rd_ff <= (wr_en && tail_ff == next_addr) ? new_entry : store_mem[next_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         idx_ff   <= 1'b0;
         left_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         left_ff  <= left_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      left_in  = left_ff;
      wr_en    = 1'b0;
      pop      = 1'b0;
      attempt  = 1'b0;
      rsp      = '0;

      if (item_valid) begin
         unique case (item.action)
            ACT_ENQUEUE: begin
               if (count_ff < CNT_W'(QUEUE_DEPTH - 1)) begin
                  wr_en          = 1'b1;
                  tail_in        = next_slot(tail_ff);
                  count_in       = count_ff + CNT_W'(1);
                  rsp.enqueue_ok = 1'b1;
                  attempt        = 1'b1;
               end
            end
            ACT_RX: begin
               unique case (phase_ff)
                  PH_WAIT_ACK: begin
                     if (item.rx_byte == codes.ack_code) begin
                        if (!idx_ff && head_rd_ff.two) begin
                           idx_in   = 1'b1;
                           phase_in = PH_NORMAL;
                        end else if (head_rd_ff.resp != '0) begin
                           left_in  = head_rd_ff.resp;
                           phase_in = PH_WAIT_RESP;
                        end else begin
                           pop              = 1'b1;
                           phase_in         = PH_NORMAL;
                           rsp.release_lock = 1'b1;
                        end
                     end else if (item.rx_byte == codes.resend_code) begin
                        phase_in = PH_NORMAL;
                     end else begin
                        rsp.forward_kind  = FWD_CMD_RESP;
                        rsp.forward_value = item.rx_byte;
                     end
                  end
                  PH_WAIT_RESP: begin
                     if (left_ff <= BYTE_W'(1)) begin
                        pop              = 1'b1;
                        phase_in         = PH_NORMAL;
                        rsp.release_lock = 1'b1;
                     end else begin
                        left_in = left_ff - BYTE_W'(1);
                     end
                     rsp.forward_kind  = FWD_DATA;
                     rsp.forward_value = item.rx_byte;
                  end
                  default: begin
                     rsp.forward_kind  = FWD_DATA;
                     rsp.forward_value = item.rx_byte;
                  end
               endcase
               attempt = 1'b1;
            end
            ACT_POLL: begin
               attempt = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (pop) begin
         if (count_ff != '0) begin
            head_in  = next_slot(head_ff);
            count_in = count_ff - CNT_W'(1);
         end
         idx_in  = 1'b0;
         left_in = '0;
      end

      // head entry source: next slot after a pop, the incoming entry on an
      // enqueue into an empty queue, else the prefetched head
      if (pop) send_entry = next_rd_ff;
      else if (count_ff == '0) send_entry = new_entry;
      else send_entry = head_rd_ff;

      if (attempt && phase_in == PH_NORMAL && count_in != '0 && item.lock_granted) begin
         phase_in       = PH_WAIT_ACK;
         rsp.send_valid = 1'b1;
         rsp.send_value = (idx_in && send_entry.two) ? send_entry.data : send_entry.cmd;
      end

      rsp.link_phase = phase_in;
   end

   `PS2DCS_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH - 1),
      "queue holds more commands than allowed")
   `PS2DCS_ASSERT_NOW(a_busy_has_cmd, phase_ff != PH_NORMAL, count_ff != '0,
      "link busy with an empty queue")
   `PS2DCS_ASSERT_NEXT(a_enq_count, item_valid && rsp.enqueue_ok,
      count_ff == $past(count_ff) + CNT_W'(1), "accepted enqueue did not grow queue")
   `PS2DCS_ASSERT_NEXT(a_send_waits, item_valid && rsp.send_valid,
      phase_ff == PH_WAIT_ACK, "sent byte without entering ack wait")

endmodule

### sv/ps2dcs_skid.sv
// Two-entry output register with skid slot for the result channel.
// Depends on ps2dcs_pkg and the shared assertion macro header.
`include "ps2_device_command_sequencer_core_macros.svh"

module ps2dcs_skid (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  ps2dcs_pkg::rsp_item_type in_item,
   output logic                     out_valid,
   input  logic                     out_ready,
   output ps2dcs_pkg::rsp_item_type out_item
);
   import ps2dcs_pkg::*;

   logic         main_valid_ff;
   logic         skid_valid_ff;
   rsp_item_type main_ff;
   rsp_item_type skid_ff;
   logic         in_fire;
   logic         out_fire;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && in_ready;
   assign out_fire  = main_valid_ff && out_ready;
   assign out_valid = main_valid_ff;
   assign out_item  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (in_fire) begin
         if (!main_valid_ff || out_fire) begin
            main_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_fire) begin
         if (skid_valid_ff) skid_valid_ff <= 1'b0;
         else main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         if (!main_valid_ff || out_fire) main_ff <= in_item;
         else skid_ff <= in_item;
      end else if (out_fire && skid_valid_ff) begin
         main_ff <= skid_ff;
      end
   end

   `PS2DCS_ASSERT_NOW(a_skid_behind_main, skid_valid_ff, main_valid_ff,
      "skid slot filled while output register empty")
   `PS2DCS_ASSERT_NEXT(a_skid_fill, main_valid_ff && !out_ready && in_valid && in_ready,
      skid_valid_ff, "stalled transaction not caught in skid slot")
   `PS2DCS_ASSERT_NEXT(a_skid_drain, skid_valid_ff && out_ready, !skid_valid_ff,
      "skid slot did not drain")

endmodule

### sv/ps2_device_command_sequencer_core.sv
// Top level of the PS/2 host command sequencer: stream ports, link code registers.
// Depends on ps2dcs_pkg, ps2dcs_seq and ps2dcs_skid.
//
// Host side command sequencer for one PS/2 device. Each req transaction is an event
// (tuser = action): enqueue a command of one or two bytes with an expected response
// count, a byte received from the device, or a poll. Every accepted req transaction
// yields exactly one rsp transaction, in order. The block takes one transaction per
// clock cycle while req_tready is high; its result is registered before it appears
// on rsp. Queue state lives in a QUEUE_DEPTH-entry command memory with one write
// port and two registered read ports that prefetch the head entry and the one after
// it, with write-through forwarding, so a command can finish and the next one start
// sending in the same transaction. The queue holds at most QUEUE_DEPTH - 1 commands;
// an enqueue beyond that is refused (enqueue_ok = 0). The memory needs no clearing
// pass after reset: entries are only read while the queue holds them. The rsp side
// has an output register plus a skid slot: a transaction accepted while the output
// register is stalled waits in the skid slot, and req_tready is low only while that
// slot is full, so a rsp stall holds back req only once that slot has filled. The ack
// and resend codes (reset 250 and 254) are to be written through the csr port only
// while the block is idle; the block itself does not enforce this. If they are equal,
// a matching byte counts as ACK.
module ps2_device_command_sequencer_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // req_tdata: cmd_byte[7:0], has_data[8], data_byte[16:9], response_count[24:17],
   //            rx_byte[32:25], lock_granted[33], zero fill[39:34]
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [ps2dcs_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // req_tuser: action[1:0]
   input  logic [1:0]                             req_tuser,
   // rsp_tdata: enqueue_ok[0], send_valid[1], send_value[9:2], forward_value[17:10],
   //            release_lock[18], link_phase[20:19], zero fill[23:21]
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [ps2dcs_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // rsp_tuser: forward_kind[1:0]
   output logic [1:0]                             rsp_tuser,
   input  logic                                   csr_wr_en,
   input  logic [ps2dcs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ps2dcs_pkg::BYTE_W-1:0]          csr_wdata
);
   import ps2dcs_pkg::*;

   logic [BYTE_W-1:0] ack_code_ff;
   logic [BYTE_W-1:0] resend_code_ff;
   link_codes_type    codes;
   req_item_type      req_item;
   rsp_item_type      seq_rsp;
   rsp_item_type      out_item;
   logic              req_fire;

   // link code registers, write only
   always_ff @(posedge clock) begin
      if (reset) begin
         ack_code_ff    <= ACK_CODE_RESET;
         resend_code_ff <= RESEND_CODE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACK_CODE:    ack_code_ff    <= csr_wdata;
            CSR_RESEND_CODE: resend_code_ff <= csr_wdata;
         endcase
      end
   end

   assign codes.ack_code    = ack_code_ff;
   assign codes.resend_code = resend_code_ff;

   // unpack the req transaction
   assign req_item.action         = req_tuser;
   assign req_item.cmd_byte       = req_tdata[7:0];
   assign req_item.has_data       = req_tdata[8];
   assign req_item.data_byte      = req_tdata[16:9];
   assign req_item.response_count = req_tdata[24:17];
   assign req_item.rx_byte        = req_tdata[32:25];
   assign req_item.lock_granted   = req_tdata[33];

   assign req_fire = req_tvalid && req_tready;

   ps2dcs_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_fire),
      .item       (req_item),
      .codes      (codes),
      .rsp        (seq_rsp)
   );

   ps2dcs_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (seq_rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   // pack the rsp transaction
   assign rsp_tdata = {3'b000, out_item.link_phase, out_item.release_lock,
                       out_item.forward_value, out_item.send_value,
                       out_item.send_valid, out_item.enqueue_ok};
   assign rsp_tuser = out_item.forward_kind;

endmodule
